@@ rtl/tawrap_pkg.sv @@
// Shared widths, codes and types for the texel address wrap unit.
`timescale 1ns / 1ps
`default_nettype none

package tawrap_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int COORD_W     = 16;
    localparam int MODE_W      = 3;
    localparam int DIM_W       = 13;
    localparam int DIV_W       = DIM_W + 1;
    localparam int MAG_W       = COORD_W;
    localparam int OUT_COORD_W = 12;
    localparam int INDEX_W     = 25;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int CFG_IDX_W   = 1;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = MAG_W / DIV_STEPS;

    localparam int IN_FIELDS_W  = 2 * COORD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * OUT_COORD_W + INDEX_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [MODE_W-1:0] MODE_CLAMP        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIRROR       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPEAT_FIRST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BLACK        = 3'd4;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIV_W-1:0] pw;
        logic [DIV_W-1:0] ph;
    } cfg_t;

    typedef struct packed {
        logic             neg;
        logic             outside;
        logic [DIM_W-1:0] base;
        logic [MAG_W-1:0] dvd;
        logic [DIV_W-1:0] dvs;
        logic [DIV_W-1:0] rem;
    } coord_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        coord_t            x;
        coord_t            y;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/texel_address_wrap.sv @@
// Throughput: one transaction per cycle while the output is not stalled; the remainder
// unit is 4 stages of 4 restoring steps each, followed by fold, multiply and add stages.
// Backpressure stalls each stage only when it holds data, so bubbles are absorbed.
// Reset clears every stage valid bit; both image dimensions reset to 1.
`timescale 1ns / 1ps
`default_nettype none

module texel_address_wrap (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tawrap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tawrap_pkg::DIM_W-1:0]       cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // coord_x[15:0], coord_y[31:16]
    input  wire logic [tawrap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  wire logic [tawrap_pkg::MODE_W-1:0]      s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // wrapped_x[11:0], wrapped_y[23:12], linear_index[48:24], zero pad above
    output logic [tawrap_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // is_black[0]
    output logic                                    m_axis_tuser
);
    import tawrap_pkg::*;

    cfg_t              cfg;
    logic              node_valid [DIV_STAGES+1];
    logic              node_ready [DIV_STAGES+1];
    item_t             node_item  [DIV_STAGES+1];
    logic [DIM_W-1:0]  wx;
    logic [DIM_W-1:0]  wy;
    logic [INDEX_W-1:0] index;

    tawrap_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tawrap_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_mode   (s_axis_tuser),
        .out_valid (node_valid[0]),
        .out_ready (node_ready[0]),
        .out_item  (node_item[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        tawrap_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (node_valid[i]),
            .in_ready  (node_ready[i]),
            .in_item   (node_item[i]),
            .out_valid (node_valid[i+1]),
            .out_ready (node_ready[i+1]),
            .out_item  (node_item[i+1])
        );
    end

    tawrap_index u_index (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (node_valid[DIV_STAGES]),
        .in_ready     (node_ready[DIV_STAGES]),
        .in_item      (node_item[DIV_STAGES]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .wrapped_x    (wx),
        .wrapped_y    (wy),
        .linear_index (index),
        .is_black     (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, index,
                           wy[OUT_COORD_W-1:0], wx[OUT_COORD_W-1:0]};

endmodule

`default_nettype wire

@@ rtl/tawrap_cfg.sv @@
// Configuration registers holding the effective image dimensions and mirror periods.
`timescale 1ns / 1ps
`default_nettype none

module tawrap_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tawrap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tawrap_pkg::DIM_W-1:0]     cfg_data,
    output tawrap_pkg::cfg_t                      cfg
);
    import tawrap_pkg::*;

    logic [DIM_W-1:0] eff_next;
    logic [DIV_W-1:0] per_next;
    cfg_t             cfg_reg;

    always_comb
    begin
        if (cfg_data == '0)
            eff_next = DIM_W'(1);
        else if (32'(cfg_data) > MAX_DIM)
            eff_next = DIM_W'(MAX_DIM);
        else
            eff_next = cfg_data;
        per_next = {eff_next, 1'b0} - DIV_W'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.w  <= DIM_W'(1);
            cfg_reg.h  <= DIM_W'(1);
            cfg_reg.pw <= '0;
            cfg_reg.ph <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    cfg_reg.w  <= eff_next;
                    cfg_reg.pw <= per_next;
                end
                REG_IMAGE_HEIGHT:
                begin
                    cfg_reg.h  <= eff_next;
                    cfg_reg.ph <= per_next;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/tawrap_prep.sv @@
// Input stage: magnitude, range test, clamp value and divisor selection per coordinate.
`timescale 1ns / 1ps
`default_nettype none

module tawrap_prep (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tawrap_pkg::cfg_t                  cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [tawrap_pkg::IN_TDATA_W-1:0] in_data,
    input  wire logic [tawrap_pkg::MODE_W-1:0]     in_mode,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output tawrap_pkg::item_t                      out_item
);
    import tawrap_pkg::*;

    function automatic coord_t prep_coord(
        input logic [COORD_W-1:0] a,
        input logic [DIM_W-1:0]   d,
        input logic [DIV_W-1:0]   p,
        input logic               mirror
    );
        coord_t           c;
        logic [MAG_W-1:0] mag;
        mag       = a[COORD_W-1] ? MAG_W'(-a) : MAG_W'(a);
        c.neg     = a[COORD_W-1];
        c.outside = c.neg || (mag >= MAG_W'(d));
        if (c.neg)
            c.base = '0;
        else if (c.outside)
            c.base = d - DIM_W'(1);
        else
            c.base = a[DIM_W-1:0];
        c.dvd = mag;
        c.dvs = mirror ? p : DIV_W'(d);
        c.rem = '0;
        return c;
    endfunction

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  mirror;

    always_comb
    begin
        mirror         = (in_mode == MODE_MIRROR);
        item_next.mode = in_mode;
        item_next.x    = prep_coord(in_data[COORD_W-1:0], cfg.w, cfg.pw, mirror);
        item_next.y    = prep_coord(in_data[2*COORD_W-1:COORD_W], cfg.h, cfg.ph, mirror);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ rtl/tawrap_div_stage.sv @@
// One stage of the pipelined remainder unit: several restoring steps on both coordinates.
`timescale 1ns / 1ps
`default_nettype none

module tawrap_div_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tawrap_pkg::item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tawrap_pkg::item_t      out_item
);
    import tawrap_pkg::*;

    function automatic coord_t div_steps(input coord_t c);
        coord_t         r;
        logic [DIV_W:0] t;
        r = c;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            t = {r.rem, r.dvd[MAG_W-1]};
            if (t >= {1'b0, r.dvs})
                t = t - {1'b0, r.dvs};
            r.rem = t[DIV_W-1:0];
            r.dvd = {r.dvd[MAG_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    always_comb
    begin
        item_next      = in_item;
        item_next.x    = div_steps(in_item.x);
        item_next.y    = div_steps(in_item.y);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ rtl/tawrap_index.sv @@
// Back end: wrap folding, row multiply and final index add, three register stages.
`timescale 1ns / 1ps
`default_nettype none

module tawrap_index (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tawrap_pkg::cfg_t             cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire tawrap_pkg::item_t            in_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [tawrap_pkg::DIM_W-1:0]      wrapped_x,
    output logic [tawrap_pkg::DIM_W-1:0]      wrapped_y,
    output logic [tawrap_pkg::INDEX_W-1:0]    linear_index,
    output logic                              is_black
);
    import tawrap_pkg::*;

    function automatic logic [DIM_W-1:0] fold(
        input coord_t            c,
        input logic [MODE_W-1:0] mode,
        input logic              outside_any,
        input logic [DIM_W-1:0]  d,
        input logic [DIV_W-1:0]  p
    );
        logic [DIM_W-1:0] r;
        case (mode)
            MODE_REPEAT:
            begin
                if (c.rem == '0 || !c.neg)
                    r = c.rem[DIM_W-1:0];
                else
                    r = d - c.rem[DIM_W-1:0];
            end
            MODE_MIRROR:
            begin
                if (d == DIM_W'(1))
                    r = '0;
                else if (c.rem >= DIV_W'(d))
                    r = DIM_W'(p - c.rem);
                else
                    r = c.rem[DIM_W-1:0];
            end
            MODE_REPEAT_FIRST, MODE_BLACK:
            begin
                r = outside_any ? '0 : c.base;
            end
            default:
            begin
                r = c.base;
            end
        endcase
        return r;
    endfunction

    logic              s1_ready;
    logic              s2_ready;
    logic              s3_ready;
    logic              outside_any;
    logic [DIM_W-1:0]  wx_next;
    logic [DIM_W-1:0]  wy_next;
    logic              black_next;
    logic [DIM_W-1:0]  row_sel;

    logic              s1_valid_reg;
    logic [DIM_W-1:0]  s1_wx_reg;
    logic [DIM_W-1:0]  s1_wy_reg;
    logic              s1_black_reg;

    logic              s2_valid_reg;
    logic [DIM_W-1:0]  s2_wx_reg;
    logic [DIM_W-1:0]  s2_wy_reg;
    logic              s2_black_reg;
    logic [PROD_W-1:0] s2_prod_reg;

    logic              s3_valid_reg;
    logic [DIM_W-1:0]  s3_wx_reg;
    logic [DIM_W-1:0]  s3_wy_reg;
    logic              s3_black_reg;
    logic [INDEX_W-1:0] s3_index_reg;
    logic [INDEX_W-1:0] index_next;

    always_comb
    begin
        outside_any = in_item.x.outside || in_item.y.outside;
        wx_next     = fold(in_item.x, in_item.mode, outside_any, cfg.w, cfg.pw);
        wy_next     = fold(in_item.y, in_item.mode, outside_any, cfg.h, cfg.ph);
        black_next  = (in_item.mode == MODE_BLACK) && outside_any;
    end

    // black texel index is w*h, so the row operand becomes h
    assign row_sel    = s1_black_reg ? cfg.h : s1_wy_reg;
    assign index_next = INDEX_W'(s2_prod_reg + (s2_black_reg ? '0 : PROD_W'(s2_wx_reg)));

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_wx_reg    <= wx_next;
            s1_wy_reg    <= wy_next;
            s1_black_reg <= black_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_wx_reg    <= s1_wx_reg;
            s2_wy_reg    <= s1_wy_reg;
            s2_black_reg <= s1_black_reg;
            s2_prod_reg  <= PROD_W'(row_sel) * PROD_W'(cfg.w);
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_wx_reg    <= s2_wx_reg;
            s3_wy_reg    <= s2_wy_reg;
            s3_black_reg <= s2_black_reg;
            s3_index_reg <= index_next;
        end
    end

    assign out_valid    = s3_valid_reg;
    assign wrapped_x    = s3_wx_reg;
    assign wrapped_y    = s3_wy_reg;
    assign linear_index = s3_index_reg;
    assign is_black     = s3_black_reg;

endmodule

`default_nettype wire
